[rtl/spatial_grid_bucket_builder_core_defines.svh]
// ----------------------------------------------------------------------------
// Spatial grid bucket builder: assertion macros
// Shared property macros for the checker of the grid builder core.
// ----------------------------------------------------------------------------
`ifndef SPATIAL_GRID_BUCKET_BUILDER_CORE_DEFINES_SVH
`define SPATIAL_GRID_BUCKET_BUILDER_CORE_DEFINES_SVH

// same-cycle implication
`define SGBB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sgbb assertion failed");

// next-cycle implication
`define SGBB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sgbb assertion failed");

`endif

[rtl/sgbb_pkg.sv]
// ----------------------------------------------------------------------------
// Spatial grid bucket builder package
// Shared types, codes and field widths of the grid builder.
// ----------------------------------------------------------------------------
package sgbb_pkg;

	localparam int unsigned IDX_W = 17;
	localparam int unsigned ID_W  = 31;
	localparam int unsigned DIV_W = 33;

	typedef enum logic [1:0] {
		MODE_LOAD    = 2'd0,
		MODE_RD_OFF  = 2'd1,
		MODE_RD_LIST = 2'd2,
		MODE_CLEAR   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_GRID  = 2'd1,
		ST_CLAMP = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

	localparam logic [1:0] CFG_CELL_SIZE = 2'd0;
	localparam logic [1:0] CFG_MAX_LAT   = 2'd1;
	localparam logic [1:0] CFG_MAX_LON   = 2'd2;

	typedef enum logic [2:0] {
		OP_NONE    = 3'd0,
		OP_LOAD    = 3'd1,
		OP_BUILD   = 3'd2,
		OP_RD_OFF  = 3'd3,
		OP_RD_LIST = 3'd4,
		OP_CLEAR   = 3'd5
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] cell_idx;
		logic [ID_W-1:0]  id;
		logic [12:0]      index;
		logic [IDX_W-1:0] cells;
	} store_req_t;

	typedef struct packed {
		logic            done;
		logic            bad;
		logic [ID_W-1:0] data;
		logic            empty;
		logic            full;
	} store_rsp_t;

endpackage

[rtl/sgbb_div.sv]
// ----------------------------------------------------------------------------
// Grid builder divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sgbb_div import sgbb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [DIV_W-1:0] num,
	input  logic [31:0]      den,
	output logic             done,
	output logic [DIV_W-1:0] quo
);

	logic [DIV_W-1:0] quo_q;
	logic [32:0]      rem_q;
	logic [31:0]      den_q;
	logic [5:0]       cnt_q;
	logic             run_q;
	logic             done_q;
	logic [32:0]      rem_sh;
	logic             ge;
	logic [32:0]      rem_nx;

	always_comb begin
		rem_sh = {rem_q[31:0], quo_q[DIV_W-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 6'(DIV_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[rtl/sgbb_store.sv]
// ----------------------------------------------------------------------------
// Grid builder store
// Point, offset and bucket memories with the counting-sort build sequencer.
// ----------------------------------------------------------------------------
module sgbb_store import sgbb_pkg::*; #(
	parameter int unsigned MAX_POINTS = 4096,
	parameter int unsigned MAX_CELLS  = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  store_req_t req,
	output store_rsp_t rsp
);

	localparam int unsigned PW  = $clog2(MAX_POINTS);
	localparam int unsigned PW1 = $clog2(MAX_POINTS + 1);
	localparam int unsigned CW  = $clog2(MAX_CELLS);
	localparam int unsigned CW1 = $clog2(MAX_CELLS + 1);
	localparam int unsigned IW  = (CW1 > PW1) ? CW1 : PW1;

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_RD    = 13'b0000000000010,
		S_RET   = 13'b0000000000100,
		S_CLR   = 13'b0000000001000,
		S_CNT_A = 13'b0000000010000,
		S_CNT_B = 13'b0000000100000,
		S_CNT_C = 13'b0000001000000,
		S_PFX_A = 13'b0000010000000,
		S_PFX_B = 13'b0000100000000,
		S_SCT_A = 13'b0001000000000,
		S_SCT_B = 13'b0010000000000,
		S_SCT_C = 13'b0100000000000,
		S_FIN   = 13'b1000000000000
	} sstate_t;

	logic [CW-1:0]   pcell_mem  [MAX_POINTS];
	logic [ID_W-1:0] pident_mem [MAX_POINTS];
	logic [PW1-1:0]  cs_mem     [MAX_CELLS+1];
	logic [PW1-1:0]  fp_mem     [MAX_CELLS];
	logic [ID_W-1:0] bl_mem     [MAX_POINTS];

	sstate_t         state_q;
	logic [PW1-1:0]  pc_q;
	logic [CW1-1:0]  cell_cnt_q;
	logic [PW1-1:0]  list_len_q;
	logic [CW1-1:0]  cells_q;
	logic [PW1-1:0]  n_q;
	logic [IW-1:0]   i_q;
	logic [PW1-1:0]  sum_q;
	logic [CW-1:0]   c_q;
	logic [CW1-1:0]  c1_q;
	logic [ID_W-1:0] id_q;
	logic [12:0]     idx_q;
	logic            list_q;
	logic            done_q;
	logic            bad_q;
	logic [ID_W-1:0] data_q;

	logic [CW-1:0]   pcell_rd_q;
	logic [ID_W-1:0] pident_rd_q;
	logic [PW1-1:0]  cs_rd_q;
	logic [PW1-1:0]  fp_rd_q;
	logic [ID_W-1:0] bl_rd_q;

	logic [PW-1:0]   pt_addr;
	logic            pt_we;
	logic [CW-1:0]   c_clamp;
	logic [CW1-1:0]  cs_raddr;
	logic            cs_we;
	logic [CW1-1:0]  cs_waddr;
	logic [PW1-1:0]  cs_wdata;
	logic [PW1-1:0]  sum_n;
	logic            fp_we;
	logic [CW-1:0]   fp_waddr;
	logic [PW1-1:0]  fp_wdata;
	logic            bl_we;

	always_comb begin
		pt_addr = i_q[PW-1:0];
		pt_we   = (state_q == S_IDLE) && (req.op == OP_LOAD);
		c_clamp = (CW1'(pcell_rd_q) >= cells_q) ? CW'(cells_q - CW1'(1)) : pcell_rd_q;
		sum_n   = sum_q + cs_rd_q;

		case (state_q)
			S_CNT_B: cs_raddr = CW1'(c_clamp) + CW1'(1);
			S_PFX_A: cs_raddr = i_q[CW1-1:0];
			default: cs_raddr = CW1'(idx_q);
		endcase

		cs_we    = 1'b0;
		cs_waddr = i_q[CW1-1:0];
		cs_wdata = '0;
		case (state_q)
			S_CLR: begin
				cs_we = 1'b1;
			end
			S_CNT_C: begin
				cs_we    = 1'b1;
				cs_waddr = c1_q;
				cs_wdata = cs_rd_q + PW1'(1);
			end
			S_PFX_B: begin
				cs_we    = 1'b1;
				cs_wdata = sum_n;
			end
			default: ;
		endcase

		fp_we    = 1'b0;
		fp_waddr = c_q;
		fp_wdata = fp_rd_q + PW1'(1);
		case (state_q)
			S_PFX_B: begin
				fp_we    = 1'b1;
				fp_waddr = CW'(i_q[CW1-1:0] - CW1'(1));
				fp_wdata = sum_q;
			end
			S_SCT_C: fp_we = 1'b1;
			default: ;
		endcase

		bl_we = (state_q == S_SCT_C);
	end

	always_ff @(posedge clk) begin
		if (pt_we) begin
			pcell_mem[pc_q[PW-1:0]]  <= req.cell_idx[CW-1:0];
			pident_mem[pc_q[PW-1:0]] <= req.id;
		end
		pcell_rd_q  <= pcell_mem[pt_addr];
		pident_rd_q <= pident_mem[pt_addr];
	end

	always_ff @(posedge clk) begin
		if (cs_we) begin
			cs_mem[cs_waddr] <= cs_wdata;
		end
		cs_rd_q <= cs_mem[cs_raddr];
	end

	always_ff @(posedge clk) begin
		if (fp_we) begin
			fp_mem[fp_waddr] <= fp_wdata;
		end
		fp_rd_q <= fp_mem[c_clamp];
	end

	always_ff @(posedge clk) begin
		if (bl_we) begin
			bl_mem[fp_rd_q[PW-1:0]] <= id_q;
		end
		bl_rd_q <= bl_mem[PW'(idx_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pc_q       <= '0;
			cell_cnt_q <= '0;
			list_len_q <= '0;
			cells_q    <= '0;
			n_q        <= '0;
			i_q        <= '0;
			sum_q      <= '0;
			c_q        <= '0;
			c1_q       <= '0;
			id_q       <= '0;
			idx_q      <= '0;
			list_q     <= 1'b0;
			done_q     <= 1'b0;
			bad_q      <= 1'b0;
			data_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					case (req.op)
						OP_LOAD: begin
							pc_q   <= pc_q + PW1'(1);
							done_q <= 1'b1;
							bad_q  <= 1'b0;
							data_q <= '0;
						end
						OP_CLEAR: begin
							pc_q       <= '0;
							cell_cnt_q <= '0;
							list_len_q <= '0;
							done_q     <= 1'b1;
						end
						OP_RD_OFF: begin
							idx_q  <= req.index;
							list_q <= 1'b0;
							bad_q  <= 1'b0;
							data_q <= '0;
							if (32'(req.index) > 32'(cell_cnt_q)) begin
								bad_q  <= 1'b1;
								done_q <= 1'b1;
							end else if (req.index == 13'd0) begin
								done_q <= 1'b1;
							end else begin
								state_q <= S_RD;
							end
						end
						OP_RD_LIST: begin
							idx_q  <= req.index;
							list_q <= 1'b1;
							bad_q  <= 1'b0;
							data_q <= '0;
							if (32'(req.index) >= 32'(list_len_q)) begin
								bad_q  <= 1'b1;
								done_q <= 1'b1;
							end else begin
								state_q <= S_RD;
							end
						end
						OP_BUILD: begin
							cells_q <= req.cells[CW1-1:0];
							n_q     <= (req.cells[CW1-1:0] == '0) ? '0 : pc_q;
							i_q     <= '0;
							bad_q   <= 1'b0;
							data_q  <= '0;
							state_q <= S_CLR;
						end
						default: ;
					endcase
				end
				S_RD: state_q <= S_RET;
				S_RET: begin
					data_q  <= list_q ? bl_rd_q : ID_W'(cs_rd_q);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_CLR: begin
					if (i_q == IW'(cells_q)) begin
						i_q     <= '0;
						state_q <= (n_q == '0) ? S_FIN : S_CNT_A;
					end else begin
						i_q <= i_q + IW'(1);
					end
				end
				S_CNT_A: state_q <= S_CNT_B;
				S_CNT_B: begin
					c1_q    <= CW1'(c_clamp) + CW1'(1);
					state_q <= S_CNT_C;
				end
				S_CNT_C: begin
					if ((i_q + IW'(1)) == IW'(n_q)) begin
						i_q     <= IW'(1);
						sum_q   <= '0;
						state_q <= S_PFX_A;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_CNT_A;
					end
				end
				S_PFX_A: state_q <= S_PFX_B;
				S_PFX_B: begin
					sum_q <= sum_n;
					if (i_q == IW'(cells_q)) begin
						i_q     <= '0;
						state_q <= S_SCT_A;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_PFX_A;
					end
				end
				S_SCT_A: state_q <= S_SCT_B;
				S_SCT_B: begin
					c_q     <= c_clamp;
					id_q    <= pident_rd_q;
					state_q <= S_SCT_C;
				end
				S_SCT_C: begin
					if ((i_q + IW'(1)) == IW'(n_q)) begin
						state_q <= S_FIN;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_SCT_A;
					end
				end
				S_FIN: begin
					cell_cnt_q <= cells_q;
					list_len_q <= n_q;
					done_q     <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp = '{
		done:  done_q,
		bad:   bad_q,
		data:  data_q,
		empty: (pc_q == '0),
		full:  (pc_q == PW1'(MAX_POINTS))
	};

endmodule

[rtl/spatial_grid_bucket_builder_core.sv]
// ----------------------------------------------------------------------------
// Spatial grid bucket builder core
// Command port: start is taken when busy is low; mode selects load point,
// read cell offset, read list entry or new set. Config writes go through
// cfg_valid/cfg_ready with cfg_index/cfg_data; the user makes them only while
// idle, the core itself does not enforce it (cfg_ready is always high).
// Each result shows for one cycle with result_valid; nothing can hold it off.
// Load: the first point of a set runs two ceiling divisions for the grid
// geometry, every stored point runs two more; each division runs 33 quotient
// steps in the one shared divider. A new set gives no result.
// A load marked last also runs the build in the sequencer: clear, count,
// prefix sum and scatter.
// busy stays high until the result strobe, or for a new set until the
// store is done.
// Reset clears counts, flags and geometry; cell_size returns to 1.0.
// ----------------------------------------------------------------------------
module spatial_grid_bucket_builder_core import sgbb_pkg::*; #(
	parameter int unsigned MAX_POINTS = 4096,
	parameter int unsigned MAX_CELLS  = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] latitude,
	input  logic [31:0] longitude,
	input  logic [30:0] point_id,
	input  logic        last_point,
	input  logic [12:0] read_index,
	output logic        result_valid,
	output logic [30:0] read_value,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int unsigned CW  = $clog2(MAX_CELLS);
	localparam int unsigned CW1 = $clog2(MAX_CELLS + 1);
	localparam int unsigned PRW = 2 * CW1;

	typedef enum logic [10:0] {
		T_IDLE      = 11'b00000000001,
		T_GEO_LAT   = 11'b00000000010,
		T_GEO_LON   = 11'b00000000100,
		T_GEO_CHK   = 11'b00000001000,
		T_LOAD_CHK  = 11'b00000010000,
		T_DIV_ROW   = 11'b00000100000,
		T_DIV_COL   = 11'b00001000000,
		T_CLAMP     = 11'b00010000000,
		T_CELL_MUL  = 11'b00100000000,
		T_BUILD_CHK = 11'b01000000000,
		T_WAIT      = 11'b10000000000
	} tstate_t;

	tstate_t          state_q;
	logic [31:0]      cell_size_q;
	logic [31:0]      max_lat_q;
	logic [31:0]      max_lon_q;
	logic [31:0]      lat_q;
	logic [31:0]      lon_q;
	logic [ID_W-1:0]  id_q;
	logic             last_q;
	logic [CW1-1:0]   rows_q;
	logic [CW1-1:0]   cols_q;
	logic [CW1-1:0]   cells_q;
	logic [1:0]       flags_q;
	logic [DIV_W-1:0] geo_r_q;
	logic [DIV_W-1:0] row_q;
	logic [CW1-1:0]   rowc_q;
	logic [CW1-1:0]   colc_q;
	logic             div_go_q;
	logic [DIV_W-1:0] div_num_q;
	op_t              op_q;
	store_req_t       req_q;
	logic [ID_W-1:0]  value_q;
	status_t          status_q;
	logic             res_q;

	logic [31:0]      cs_eff;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;
	logic [DIV_W-1:0] quo_min1;
	logic [PRW-1:0]   geo_prod;
	logic             geo_big;
	logic [PRW-1:0]   cell_sum;
	logic             row_out;
	logic             col_out;
	store_rsp_t       rsp;

	always_comb begin
		cs_eff   = (cell_size_q == 32'd0) ? 32'd1 : cell_size_q;
		quo_min1 = (div_quo == '0) ? DIV_W'(1) : div_quo;
		geo_prod = PRW'(geo_r_q[CW1-1:0]) * PRW'(quo_min1[CW1-1:0]);
		geo_big  = (geo_r_q > DIV_W'(MAX_CELLS)) || (quo_min1 > DIV_W'(MAX_CELLS))
			|| (geo_prod > PRW'(MAX_CELLS));
		cell_sum = PRW'(rowc_q) * PRW'(cols_q) + PRW'(colc_q);
		row_out  = row_q >= DIV_W'(rows_q);
		col_out  = div_quo >= DIV_W'(cols_q);
	end

	sgbb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go_q),
		.num    (div_num_q),
		.den    (cs_eff),
		.done   (div_done),
		.quo    (div_quo)
	);

	sgbb_store #(
		.MAX_POINTS (MAX_POINTS),
		.MAX_CELLS  (MAX_CELLS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= 32'h0001_0000;
			max_lat_q   <= '0;
			max_lon_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CELL_SIZE: cell_size_q <= cfg_data;
				CFG_MAX_LAT:   max_lat_q   <= cfg_data;
				CFG_MAX_LON:   max_lon_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			lat_q     <= '0;
			lon_q     <= '0;
			id_q      <= '0;
			last_q    <= 1'b0;
			rows_q    <= '0;
			cols_q    <= '0;
			cells_q   <= '0;
			flags_q   <= '0;
			geo_r_q   <= '0;
			row_q     <= '0;
			rowc_q    <= '0;
			colc_q    <= '0;
			div_go_q  <= 1'b0;
			div_num_q <= '0;
			op_q      <= OP_NONE;
			req_q     <= '0;
			value_q   <= '0;
			status_q  <= ST_OK;
			res_q     <= 1'b0;
		end else begin
			div_go_q  <= 1'b0;
			req_q.op  <= OP_NONE;
			res_q     <= 1'b0;
			case (state_q)
				T_IDLE: begin
					if (start) begin
						lat_q    <= latitude;
						lon_q    <= longitude;
						id_q     <= point_id;
						last_q   <= last_point;
						value_q  <= '0;
						status_q <= ST_OK;
						case (mode_t'(mode))
							MODE_LOAD: begin
								if (rsp.empty) begin
									div_go_q  <= 1'b1;
									div_num_q <= {1'b0, max_lat_q} + {1'b0, cs_eff} - DIV_W'(1);
									state_q   <= T_GEO_LAT;
								end else begin
									state_q <= T_LOAD_CHK;
								end
							end
							MODE_RD_OFF: begin
								req_q.op    <= OP_RD_OFF;
								req_q.index <= read_index;
								op_q        <= OP_RD_OFF;
								state_q     <= T_WAIT;
							end
							MODE_RD_LIST: begin
								req_q.op    <= OP_RD_LIST;
								req_q.index <= read_index;
								op_q        <= OP_RD_LIST;
								state_q     <= T_WAIT;
							end
							MODE_CLEAR: begin
								rows_q   <= '0;
								cols_q   <= '0;
								cells_q  <= '0;
								flags_q  <= '0;
								req_q.op <= OP_CLEAR;
								op_q     <= OP_CLEAR;
								state_q  <= T_WAIT;
							end
							default: ;
						endcase
					end
				end
				T_GEO_LAT: begin
					if (div_done) begin
						geo_r_q   <= quo_min1;
						div_go_q  <= 1'b1;
						div_num_q <= {1'b0, max_lon_q} + {1'b0, cs_eff} - DIV_W'(1);
						state_q   <= T_GEO_LON;
					end
				end
				T_GEO_LON: begin
					if (div_done) begin
						state_q <= T_GEO_CHK;
					end
				end
				T_GEO_CHK: begin
					if (geo_big) begin
						flags_q[0] <= 1'b1;
						rows_q     <= '0;
						cols_q     <= '0;
						cells_q    <= '0;
					end else begin
						flags_q[0] <= 1'b0;
						rows_q     <= geo_r_q[CW1-1:0];
						cols_q     <= quo_min1[CW1-1:0];
						cells_q    <= geo_prod[CW1-1:0];
					end
					state_q <= T_LOAD_CHK;
				end
				T_LOAD_CHK: begin
					if (flags_q[0]) begin
						status_q <= ST_GRID;
						state_q  <= T_BUILD_CHK;
					end else if (rsp.full) begin
						status_q <= ST_BAD;
						state_q  <= T_BUILD_CHK;
					end else begin
						div_go_q  <= 1'b1;
						div_num_q <= {1'b0, lat_q};
						state_q   <= T_DIV_ROW;
					end
				end
				T_DIV_ROW: begin
					if (div_done) begin
						row_q     <= div_quo;
						div_go_q  <= 1'b1;
						div_num_q <= {1'b0, lon_q};
						state_q   <= T_DIV_COL;
					end
				end
				T_DIV_COL: begin
					if (div_done) begin
						state_q <= T_CLAMP;
					end
				end
				T_CLAMP: begin
					rowc_q <= row_out ? rows_q - CW1'(1) : row_q[CW1-1:0];
					colc_q <= col_out ? cols_q - CW1'(1) : div_quo[CW1-1:0];
					if (row_out || col_out) begin
						status_q   <= ST_CLAMP;
						flags_q[1] <= 1'b1;
					end
					state_q <= T_CELL_MUL;
				end
				T_CELL_MUL: begin
					req_q.op       <= OP_LOAD;
					req_q.cell_idx <= IDX_W'(cell_sum[CW-1:0]);
					req_q.id       <= id_q;
					op_q           <= OP_LOAD;
					state_q        <= T_WAIT;
				end
				T_BUILD_CHK: begin
					if (last_q) begin
						req_q.op    <= OP_BUILD;
						req_q.cells <= IDX_W'(cells_q);
						op_q        <= OP_BUILD;
						state_q     <= T_WAIT;
					end else begin
						res_q   <= 1'b1;
						state_q <= T_IDLE;
					end
				end
				T_WAIT: begin
					if (rsp.done) begin
						case (op_q)
							OP_LOAD: state_q <= T_BUILD_CHK;
							OP_BUILD: begin
								res_q   <= 1'b1;
								state_q <= T_IDLE;
							end
							OP_RD_OFF, OP_RD_LIST: begin
								value_q  <= rsp.data;
								status_q <= rsp.bad ? ST_BAD : ST_OK;
								res_q    <= 1'b1;
								state_q  <= T_IDLE;
							end
							default: state_q <= T_IDLE;
						endcase
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != T_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = res_q;
	assign read_value   = value_q;
	assign status       = status_q;

endmodule

[rtl/sgbb_checker.sv]
// ----------------------------------------------------------------------------
// Grid builder port checker
// Port-level properties of the grid builder core, bound to the top level.
// ----------------------------------------------------------------------------
`include "spatial_grid_bucket_builder_core_defines.svh"

module sgbb_checker import sgbb_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        result_valid,
	input logic [30:0] read_value,
	input logic [1:0]  status
);

	logic load_res;

	assign load_res = result_valid && (status == ST_GRID || status == ST_CLAMP);

	`SGBB_ASSERT_NXT(a_strobe_single, clk, arst_n, result_valid, !result_valid)
	`SGBB_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`SGBB_ASSERT_IMP(a_strobe_idle, clk, arst_n, result_valid, !busy)
	`SGBB_ASSERT_IMP(a_load_zero, clk, arst_n, load_res, read_value == 31'd0)

endmodule

bind spatial_grid_bucket_builder_core sgbb_checker u_sgbb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.read_value   (read_value),
	.status       (status)
);

[dv/tb_spatial_grid_bucket_builder_core.sv]
// ----------------------------------------------------------------------------
// Spatial grid bucket builder core testbench
// Drives point loads, builds, offset and list reads and new-set commands
// through the command port, with bursts and gaps on the sender side. A
// grid model in the testbench predicts every result and checks it in order.
// ----------------------------------------------------------------------------
module tb_spatial_grid_bucket_builder_core;
	import sgbb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NPTS   = 4096;
	localparam int unsigned NCELLS = 4096;
	localparam int unsigned STALL_LIMIT = 300000;

	typedef struct packed {
		logic [30:0] value;
		status_t     st;
	} grid_result_t;

	class bucket_grid_model;
		logic [31:0]  cell_size, max_lat, max_lon;
		int unsigned  point_cell[NPTS];
		logic [30:0]  point_ident[NPTS];
		int unsigned  cell_start[NCELLS+1];
		logic [30:0]  bucket_list[NPTS];
		int unsigned  fill_pos[NCELLS];
		int unsigned  npoints, rows, cols, cell_count, list_length;
		logic [1:0]   flags;
		grid_result_t expected_reads[$];
		int unsigned  mismatches;

		function new();
			cell_size = 32'h0001_0000;
			max_lat = 0;
			max_lon = 0;
			mismatches = 0;
			clear_set();
		endfunction

		function void clear_set();
			npoints = 0;
			rows = 0;
			cols = 0;
			flags = 0;
			cell_count = 0;
			list_length = 0;
			foreach (cell_start[i]) cell_start[i] = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] data);
			if (idx == CFG_CELL_SIZE) cell_size = data;
			else if (idx == CFG_MAX_LAT) max_lat = data;
			else if (idx == CFG_MAX_LON) max_lon = data;
		endfunction

		function longint unsigned ceil_div_min1(logic [31:0] num, logic [31:0] den);
			longint unsigned q;
			q = (longint'(num) + longint'(den) - 1) / longint'(den);
			return (q == 0) ? 1 : q;
		endfunction

		function void latch_geometry();
			logic [31:0] cs;
			longint unsigned r, c;
			cs = (cell_size == 0) ? 32'd1 : cell_size;
			r = ceil_div_min1(max_lat, cs);
			c = ceil_div_min1(max_lon, cs);
			if (r > NCELLS || c > NCELLS || r * c > NCELLS) begin
				flags[0] = 1'b1;
				rows = 0;
				cols = 0;
			end else begin
				flags[0] = 1'b0;
				rows = r[31:0];
				cols = c[31:0];
			end
		endfunction

		function void build_grid();
			int unsigned cells, n, c, p;
			cells = flags[0] ? 0 : rows * cols;
			n = npoints;
			foreach (cell_start[i]) cell_start[i] = 0;
			if (cells == 0) n = 0;
			for (int unsigned i = 0; i < n; i++) begin
				c = (point_cell[i] >= cells) ? cells - 1 : point_cell[i];
				cell_start[c+1]++;
			end
			for (int unsigned i = 1; i <= cells; i++) cell_start[i] += cell_start[i-1];
			for (int unsigned i = 0; i < cells; i++) fill_pos[i] = cell_start[i];
			for (int unsigned i = 0; i < n; i++) begin
				c = (point_cell[i] >= cells) ? cells - 1 : point_cell[i];
				p = fill_pos[c]++;
				if (p < NPTS) bucket_list[p] = point_ident[i];
			end
			cell_count = cells;
			list_length = n;
		endfunction

		function void note_command(mode_t m, logic [31:0] lat, logic [31:0] lon,
				logic [30:0] id, logic last, logic [12:0] idx);
			grid_result_t r;
			logic [31:0] cs;
			int unsigned row, col;
			r.value = '0;
			r.st = ST_OK;
			case (m)
				MODE_CLEAR: begin
					clear_set();
					return;
				end
				MODE_LOAD: begin
					if (npoints == 0) latch_geometry();
					if (flags[0]) begin
						r.st = ST_GRID;
					end else if (npoints >= NPTS) begin
						r.st = ST_BAD;
					end else begin
						cs = (cell_size == 0) ? 32'd1 : cell_size;
						row = lat / cs;
						col = lon / cs;
						if (row >= rows) begin
							row = rows - 1;
							r.st = ST_CLAMP;
						end
						if (col >= cols) begin
							col = cols - 1;
							r.st = ST_CLAMP;
						end
						if (r.st == ST_CLAMP) flags[1] = 1'b1;
						point_cell[npoints] = row * cols + col;
						point_ident[npoints] = id;
						npoints++;
					end
					if (last) build_grid();
				end
				MODE_RD_OFF: begin
					if (idx <= cell_count) r.value = 31'(cell_start[idx]);
					else r.st = ST_BAD;
				end
				default: begin
					if (idx < list_length) r.value = bucket_list[idx];
					else r.st = ST_BAD;
				end
			endcase
			expected_reads = {expected_reads, r};
		endfunction

		function void check_result(logic [30:0] value, logic [1:0] st);
			grid_result_t e;
			if (expected_reads.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: read_value=%0d status=%0d", value, st);
				return;
			end
			e = expected_reads.pop_front();
			if (value !== e.value || st !== e.st) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: read_value exp %0d got %0d, status exp %0d got %0d",
						e.value, value, e.st, st);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	mode_t       mode = MODE_LOAD;
	logic [31:0] latitude = '0;
	logic [31:0] longitude = '0;
	logic [30:0] point_id = '0;
	logic        last_point = 1'b0;
	logic [12:0] read_index = '0;
	logic        result_valid;
	logic [30:0] read_value;
	logic [1:0]  status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	bucket_grid_model grid = new();
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	int unsigned idle_cycles = 0;
	logic [31:0] span_lat, span_lon;

	always #5 clk = ~clk;

	spatial_grid_bucket_builder_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.latitude(latitude), .longitude(longitude), .point_id(point_id),
		.last_point(last_point), .read_index(read_index),
		.result_valid(result_valid), .read_value(read_value), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always @(posedge clk) begin
		if (arst_n && result_valid) grid.check_result(read_value, status);
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_spatial_grid_bucket_builder_core: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_command(mode_t m, logic [31:0] lat, logic [31:0] lon,
			logic [30:0] id, logic last, logic [12:0] idx);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		start <= 1'b1;
		mode <= m;
		latitude <= lat;
		longitude <= lon;
		point_id <= id;
		last_point <= last;
		read_index <= idx;
		do @(posedge clk); while (busy);
		grid.note_command(m, lat, lon, id, last, idx);
		items_sent++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (grid.expected_reads.size() != 0 || busy);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		grid.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(logic [31:0] cs, logic [31:0] mlat, logic [31:0] mlon);
		wait_drained();
		write_reg(CFG_CELL_SIZE, cs);
		write_reg(CFG_MAX_LAT, mlat);
		write_reg(CFG_MAX_LON, mlon);
	endtask

	function automatic logic [31:0] pick_coord(logic [31:0] span);
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 8) return $urandom_range(0, span);
		return $urandom;
	endfunction

	task automatic read_back(int unsigned count);
		logic [12:0] idx;
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(0, 7) == 0) idx = 13'($urandom);
			else idx = 13'($urandom_range(0, grid.cell_count + 1));
			if ($urandom_range(0, 1)) begin
				send_command(MODE_RD_OFF, $urandom, $urandom, 31'($urandom),
					1'($urandom), idx);
			end else begin
				if ($urandom_range(0, 7) != 0) idx = 13'($urandom_range(0, grid.list_length));
				send_command(MODE_RD_LIST, $urandom, $urandom, 31'($urandom),
					1'($urandom), idx);
			end
		end
	endtask

	task automatic random_phase();
		logic [31:0] cs;
		longint unsigned span;
		int unsigned nloads;
		case ($urandom_range(0, 4))
			0: cs = $urandom_range(1, 255);
			1, 2: cs = $urandom_range(256, 32'h0004_0000);
			3: cs = $urandom | 32'd1;
			default: cs = 32'hFFFF_FFFF;
		endcase
		span = longint'(cs) * $urandom_range(1, 12) - $urandom_range(0, cs - 1);
		span_lat = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
		span = longint'(cs) * $urandom_range(1, 12) - $urandom_range(0, cs - 1);
		span_lon = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
		if ($urandom_range(0, 19) == 0) span_lat = 0;
		if ($urandom_range(0, 19) == 0) span_lon = $urandom;
		configure(cs, span_lat, span_lon);
		if ($urandom_range(0, 9) != 0)
			send_command(MODE_CLEAR, $urandom, $urandom, 31'($urandom), 1'($urandom),
				13'($urandom));
		nloads = $urandom_range(1, 20);
		for (int unsigned i = 0; i < nloads; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_command(mode_t'(2'($urandom_range(0, 3))), $urandom, $urandom,
					31'($urandom), 1'($urandom), 13'($urandom));
			send_command(MODE_LOAD, pick_coord(span_lat), pick_coord(span_lon),
				31'($urandom), (i == nloads - 1) || ($urandom_range(0, 19) == 0),
				13'($urandom));
		end
		read_back($urandom_range(4, 15));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single cell, corners clamp
		configure(32'h0001_0000, 32'd0, 32'd0);
		send_command(MODE_CLEAR, '0, '0, '0, 1'b0, '0);
		send_command(MODE_LOAD, '0, '0, '0, 1'b0, '0);
		send_command(MODE_LOAD, '1, '1, '1, 1'b1, '1);
		send_command(MODE_RD_OFF, '0, '0, '0, 1'b0, 13'd0);
		send_command(MODE_RD_OFF, '0, '0, '0, 1'b0, 13'd1);
		send_command(MODE_RD_OFF, '0, '0, '0, 1'b0, 13'd2);
		send_command(MODE_RD_LIST, '0, '0, '0, 1'b0, 13'd0);
		send_command(MODE_RD_LIST, '0, '0, '0, 1'b0, 13'd1);
		send_command(MODE_RD_LIST, '0, '0, '0, 1'b0, 13'd2);
		send_command(MODE_RD_OFF, '0, '0, '0, 1'b0, 13'h1FFF);
		// grid larger than the cell store
		configure(32'd1, 32'd100, 32'd100);
		send_command(MODE_CLEAR, '0, '0, '0, 1'b0, '0);
		send_command(MODE_LOAD, 32'd5, 32'd5, 31'd9, 1'b1, '0);
		send_command(MODE_RD_OFF, '0, '0, '0, 1'b0, 13'd0);
		send_command(MODE_RD_OFF, '0, '0, '0, 1'b0, 13'd1);
		// zero cell size taken as one
		configure(32'd0, 32'd3, 32'd0);
		send_command(MODE_CLEAR, '0, '0, '0, 1'b0, '0);
		send_command(MODE_LOAD, 32'd2, 32'd0, 31'd77, 1'b1, '0);
		send_command(MODE_RD_LIST, '0, '0, '0, 1'b0, 13'd0);
		send_command(MODE_RD_OFF, '0, '0, '0, 1'b0, 13'd3);
		// all-ones registers
		configure('1, '1, '1);
		send_command(MODE_CLEAR, '0, '0, '0, 1'b0, '0);
		send_command(MODE_LOAD, '1, 32'h8000_0000, 31'h5555_5555, 1'b1, '0);
		send_command(MODE_RD_LIST, '0, '0, '0, 1'b0, 13'd0);

		while (items_sent < 1500) random_phase();

		start <= 1'b0;
		do @(posedge clk); while (grid.expected_reads.size() != 0);
		repeat (300) @(posedge clk);
		if (grid.mismatches == 0 && grid.expected_reads.size() == 0) begin
			$display("tb_spatial_grid_bucket_builder_core: done, clean");
		end else begin
			$display("tb_spatial_grid_bucket_builder_core: done, errors");
		end
		$finish;
	end

endmodule
